>>> design/mau_pkg.sv
package mau_pkg;

  localparam int MOD_W  = 63;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 3;

  typedef logic [MOD_W-1:0]  mod_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam logic [2:0] FN_REDUCE = 3'd0;
  localparam logic [2:0] FN_ADD    = 3'd1;
  localparam logic [2:0] FN_SUB    = 3'd2;
  localparam logic [2:0] FN_MUL    = 3'd3;
  localparam logic [2:0] FN_DIV    = 3'd4;
  localparam logic [2:0] FN_POW    = 3'd5;
  localparam logic [2:0] FN_NEG    = 3'd6;
  localparam logic [2:0] FN_INV    = 3'd7;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_ZERO    = 2'd1;
  localparam logic [1:0] ERR_COPRIME = 2'd2;

  localparam logic [ADDR_W-1:0] REG_MODULUS = 3'd0;
  localparam mod_t MOD_RESET = 63'd2;

  // a, b below m
  function automatic mod_t add_mod(mod_t a, mod_t b, mod_t m);
    logic [MOD_W:0] s;
    logic [MOD_W:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, m};
    add_mod = (s >= {1'b0, m}) ? d[MOD_W-1:0] : s[MOD_W-1:0];
  endfunction

  // wraps in MOD_W bits; the true result lies below m
  function automatic mod_t sub_mod(mod_t a, mod_t b, mod_t m);
    sub_mod = (a >= b) ? (a - b) : (a - b + m);
  endfunction

  function automatic word_t magnitude(word_t v);
    magnitude = v[DATA_W-1] ? (~v + 64'd1) : v;
  endfunction

endpackage

>>> design/modular_arithmetic_unit.sv
// Modular arithmetic unit: one result per input transaction, modulo the
// configured modulus (at least two; writes of 0 or 1 are dropped).
// Input channel: in_valid / in_stall with in_func, in_operand_a, in_operand_b.
// Output channel: out_valid / out_stall with out_result and out_error.
// Configuration: APB-style port, modulus at byte address 0 (64-bit data).
// Write it only while the unit is idle.
// Latency depends on the operation and the operands. Each operand reduction
// runs the bit-serial divider once. A modular multiply steps through the
// bits of its multiplier and stops once the remaining bits are zero.
// Add, subtract, negate and reduce need only the two reductions; multiply
// adds one modular multiply. Inverse runs one Euclid step per divide plus a
// modular multiply. Power does up to two modular multiplies per exponent bit.
// One transaction is in work at a time; in_stall is high while it runs.
// A finished result sits in the output register while the next transaction
// is taken; with out_stall high the result holds and the next one waits.
// Reset clears the modulus to two and drops any pending result.
module modular_arithmetic_unit
  import mau_pkg::*;
#(
  parameter int WORD_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_func,
  input  logic signed [WORD_WIDTH-1:0] in_operand_a,
  input  logic signed [WORD_WIDTH-1:0] in_operand_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [MOD_W-1:0]             out_result,
  output logic [1:0]                   out_error,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ADDR_W-1:0]            cfg_paddr,
  input  logic [DATA_W-1:0]            cfg_pwdata,
  output logic [DATA_W-1:0]            cfg_prdata,
  output logic                         cfg_pready
);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_DIV_GO   = 5'd1;
  localparam logic [4:0] ST_DIV_W    = 5'd2;
  localparam logic [4:0] ST_MUL_GO   = 5'd3;
  localparam logic [4:0] ST_MUL_W    = 5'd4;
  localparam logic [4:0] ST_RA_FIX   = 5'd5;
  localparam logic [4:0] ST_RB_FIX   = 5'd6;
  localparam logic [4:0] ST_DISP     = 5'd7;
  localparam logic [4:0] ST_FIN_MUL  = 5'd8;
  localparam logic [4:0] ST_DIV_INV  = 5'd9;
  localparam logic [4:0] ST_POW_INV  = 5'd10;
  localparam logic [4:0] ST_POW_LOOP = 5'd11;
  localparam logic [4:0] ST_POW_ACC  = 5'd12;
  localparam logic [4:0] ST_POW_SQ   = 5'd13;
  localparam logic [4:0] ST_POW_SQD  = 5'd14;
  localparam logic [4:0] ST_FIN_INV  = 5'd15;
  localparam logic [4:0] ST_INV      = 5'd16;
  localparam logic [4:0] ST_INV_LOOP = 5'd17;
  localparam logic [4:0] ST_INV_Q    = 5'd18;
  localparam logic [4:0] ST_INV_UPD  = 5'd19;
  localparam logic [4:0] ST_DONE     = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic [4:0] dret_r, dret_nxt;
  logic [4:0] mret_r, mret_nxt;
  logic [4:0] iret_r, iret_nxt;
  logic [2:0] func_r, func_nxt;
  logic       sa_neg_r, sa_neg_nxt;
  word_t      sb_r, sb_nxt;
  word_t      e_r, e_nxt;
  word_t      dop_n_r, dop_n_nxt;
  mod_t       dop_d_r, dop_d_nxt;
  mod_t       mop_a_r, mop_a_nxt;
  mod_t       mop_b_r, mop_b_nxt;
  mod_t       ra_r, ra_nxt;
  mod_t       rb_r, rb_nxt;
  mod_t       acc_r, acc_nxt;
  mod_t       base_r, base_nxt;
  mod_t       v1_r, v1_nxt;
  mod_t       v2_r, v2_nxt;
  mod_t       c1_r, c1_nxt;
  mod_t       c2_r, c2_nxt;
  mod_t       inv_x_r, inv_x_nxt;
  mod_t       inv_res_r, inv_res_nxt;
  logic [1:0] inv_err_r, inv_err_nxt;
  mod_t       res_r, res_nxt;
  logic [1:0] err_r, err_nxt;
  mod_t       mod_r;
  logic       out_valid_r;
  mod_t       out_result_r;
  logic [1:0] out_error_r;

  logic  div_start, div_done, mul_start, mul_done;
  word_t div_quot;
  mod_t  div_rem, mul_prod, rfix;
  word_t sa, sb;
  logic  cfg_wr;

  assign sa = DATA_W'(in_operand_a);
  assign sb = DATA_W'(in_operand_b);

  mau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dop_n_r),
    .divisor  (dop_d_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  mau_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mop_a_r),
    .op_b    (mop_b_r),
    .modulus (mod_r),
    .done    (mul_done),
    .prod    (mul_prod)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign rfix     = (div_rem == '0) ? '0 : (mod_r - div_rem);

  always_comb begin
    state_nxt   = state_r;
    dret_nxt    = dret_r;
    mret_nxt    = mret_r;
    iret_nxt    = iret_r;
    func_nxt    = func_r;
    sa_neg_nxt  = sa_neg_r;
    sb_nxt      = sb_r;
    e_nxt       = e_r;
    dop_n_nxt   = dop_n_r;
    dop_d_nxt   = dop_d_r;
    mop_a_nxt   = mop_a_r;
    mop_b_nxt   = mop_b_r;
    ra_nxt      = ra_r;
    rb_nxt      = rb_r;
    acc_nxt     = acc_r;
    base_nxt    = base_r;
    v1_nxt      = v1_r;
    v2_nxt      = v2_r;
    c1_nxt      = c1_r;
    c2_nxt      = c2_r;
    inv_x_nxt   = inv_x_r;
    inv_res_nxt = inv_res_r;
    inv_err_nxt = inv_err_r;
    res_nxt     = res_r;
    err_nxt     = err_r;
    div_start   = 1'b0;
    mul_start   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          sa_neg_nxt = sa[DATA_W-1];
          sb_nxt     = sb;
          dop_n_nxt  = magnitude(sa);
          dop_d_nxt  = mod_r;
          dret_nxt   = ST_RA_FIX;
          state_nxt  = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_W;
      end
      ST_DIV_W: begin
        if (div_done) state_nxt = dret_r;
      end
      ST_MUL_GO: begin
        mul_start = 1'b1;
        state_nxt = ST_MUL_W;
      end
      ST_MUL_W: begin
        if (mul_done) state_nxt = mret_r;
      end
      ST_RA_FIX: begin
        ra_nxt    = sa_neg_r ? rfix : div_rem;
        dop_n_nxt = magnitude(sb_r);
        dret_nxt  = ST_RB_FIX;
        state_nxt = ST_DIV_GO;
      end
      ST_RB_FIX: begin
        rb_nxt    = sb_r[DATA_W-1] ? rfix : div_rem;
        state_nxt = ST_DISP;
      end
      ST_DISP: begin
        err_nxt = ERR_OK;
        unique case (func_r)
          FN_REDUCE: begin
            res_nxt   = ra_r;
            state_nxt = ST_DONE;
          end
          FN_ADD: begin
            res_nxt   = add_mod(ra_r, rb_r, mod_r);
            state_nxt = ST_DONE;
          end
          FN_SUB: begin
            res_nxt   = sub_mod(ra_r, rb_r, mod_r);
            state_nxt = ST_DONE;
          end
          FN_NEG: begin
            res_nxt   = (ra_r == '0) ? '0 : (mod_r - ra_r);
            state_nxt = ST_DONE;
          end
          FN_MUL: begin
            mop_a_nxt = ra_r;
            mop_b_nxt = rb_r;
            mret_nxt  = ST_FIN_MUL;
            state_nxt = ST_MUL_GO;
          end
          FN_DIV: begin
            inv_x_nxt = rb_r;
            iret_nxt  = ST_DIV_INV;
            state_nxt = ST_INV;
          end
          FN_POW: begin
            if (sb_r == '0) begin
              res_nxt   = MOD_W'(1);
              state_nxt = ST_DONE;
            end else if (sb_r[DATA_W-1]) begin
              inv_x_nxt = ra_r;
              iret_nxt  = ST_POW_INV;
              state_nxt = ST_INV;
            end else begin
              base_nxt  = ra_r;
              e_nxt     = sb_r;
              acc_nxt   = MOD_W'(1);
              state_nxt = ST_POW_LOOP;
            end
          end
          FN_INV: begin
            inv_x_nxt = ra_r;
            iret_nxt  = ST_FIN_INV;
            state_nxt = ST_INV;
          end
        endcase
      end
      ST_FIN_MUL: begin
        res_nxt   = mul_prod;
        err_nxt   = ERR_OK;
        state_nxt = ST_DONE;
      end
      ST_DIV_INV: begin
        if (inv_err_r != ERR_OK) begin
          res_nxt   = '0;
          err_nxt   = inv_err_r;
          state_nxt = ST_DONE;
        end else begin
          mop_a_nxt = ra_r;
          mop_b_nxt = inv_res_r;
          mret_nxt  = ST_FIN_MUL;
          state_nxt = ST_MUL_GO;
        end
      end
      ST_POW_INV: begin
        if (inv_err_r != ERR_OK) begin
          res_nxt   = '0;
          err_nxt   = inv_err_r;
          state_nxt = ST_DONE;
        end else begin
          base_nxt  = inv_res_r;
          e_nxt     = ~sb_r + 64'd1;
          acc_nxt   = MOD_W'(1);
          state_nxt = ST_POW_LOOP;
        end
      end
      ST_POW_LOOP: begin
        if (e_r == '0) begin
          res_nxt   = acc_r;
          err_nxt   = ERR_OK;
          state_nxt = ST_DONE;
        end else if (e_r[0]) begin
          mop_a_nxt = acc_r;
          mop_b_nxt = base_r;
          mret_nxt  = ST_POW_ACC;
          state_nxt = ST_MUL_GO;
        end else begin
          state_nxt = ST_POW_SQ;
        end
      end
      ST_POW_ACC: begin
        acc_nxt   = mul_prod;
        state_nxt = ST_POW_SQ;
      end
      ST_POW_SQ: begin
        mop_a_nxt = base_r;
        mop_b_nxt = base_r;
        mret_nxt  = ST_POW_SQD;
        state_nxt = ST_MUL_GO;
      end
      ST_POW_SQD: begin
        base_nxt  = mul_prod;
        e_nxt     = {1'b0, e_r[DATA_W-1:1]};
        state_nxt = ST_POW_LOOP;
      end
      ST_FIN_INV: begin
        res_nxt   = inv_res_r;
        err_nxt   = inv_err_r;
        state_nxt = ST_DONE;
      end
      // Euclid with coefficients kept modulo m
      ST_INV: begin
        if (inv_x_r == '0) begin
          inv_res_nxt = '0;
          inv_err_nxt = ERR_ZERO;
          state_nxt   = iret_r;
        end else begin
          v1_nxt    = mod_r;
          v2_nxt    = inv_x_r;
          c1_nxt    = '0;
          c2_nxt    = MOD_W'(1);
          state_nxt = ST_INV_LOOP;
        end
      end
      ST_INV_LOOP: begin
        if (v2_r == '0) begin
          if (v1_r != MOD_W'(1)) begin
            inv_res_nxt = '0;
            inv_err_nxt = ERR_COPRIME;
          end else begin
            inv_res_nxt = c1_r;
            inv_err_nxt = ERR_OK;
          end
          state_nxt = iret_r;
        end else begin
          dop_n_nxt = {1'b0, v1_r};
          dop_d_nxt = v2_r;
          dret_nxt  = ST_INV_Q;
          state_nxt = ST_DIV_GO;
        end
      end
      ST_INV_Q: begin
        v1_nxt    = v2_r;
        v2_nxt    = div_rem;
        mop_a_nxt = c2_r;
        mop_b_nxt = div_quot[MOD_W-1:0];
        mret_nxt  = ST_INV_UPD;
        state_nxt = ST_MUL_GO;
      end
      ST_INV_UPD: begin
        c1_nxt    = c2_r;
        c2_nxt    = sub_mod(c1_r, mul_prod, mod_r);
        state_nxt = ST_INV_LOOP;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mod_r       <= MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // drop writes of a modulus below two
      if (cfg_wr && cfg_paddr == REG_MODULUS && cfg_pwdata[MOD_W-1:0] >= MOD_W'(2)) begin
        mod_r <= cfg_pwdata[MOD_W-1:0];
      end
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_result_r <= res_r;
      out_error_r  <= err_r;
    end
    dret_r    <= dret_nxt;
    mret_r    <= mret_nxt;
    iret_r    <= iret_nxt;
    func_r    <= func_nxt;
    sa_neg_r  <= sa_neg_nxt;
    sb_r      <= sb_nxt;
    e_r       <= e_nxt;
    dop_n_r   <= dop_n_nxt;
    dop_d_r   <= dop_d_nxt;
    mop_a_r   <= mop_a_nxt;
    mop_b_r   <= mop_b_nxt;
    ra_r      <= ra_nxt;
    rb_r      <= rb_nxt;
    acc_r     <= acc_nxt;
    base_r    <= base_nxt;
    v1_r      <= v1_nxt;
    v2_r      <= v2_nxt;
    c1_r      <= c1_nxt;
    c2_r      <= c2_nxt;
    inv_x_r   <= inv_x_nxt;
    inv_res_r <= inv_res_nxt;
    inv_err_r <= inv_err_nxt;
    res_r     <= res_nxt;
    err_r     <= err_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_error  = out_error_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_MODULUS) ? {1'b0, mod_r} : '0;

  a_mod_min: assert property (@(posedge clk) disable iff (!rst_n)
    mod_r >= MOD_W'(2))
    else $error("modulus below two");

  a_err_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r != ERR_OK) |-> out_result_r == '0)
    else $error("failed inverse with nonzero result");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_error_r == ERR_OK || out_error_r == ERR_ZERO ||
                     out_error_r == ERR_COPRIME))
    else $error("undefined error code");

  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_stall) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not delivered to output register");

endmodule

>>> design/mau_div.sv
module mau_div
  import mau_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t dividend,
  input  mod_t  divisor,
  output logic  done,
  output word_t quot,
  output mod_t  rem
);

  logic       busy_r, busy_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  word_t      q_r, q_nxt;
  mod_t       rem_r, rem_nxt;
  logic       done_r, done_nxt;
  logic [MOD_W:0] trial;
  logic [MOD_W:0] diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, q_r[DATA_W-1]};
    diff     = trial - {1'b0, divisor};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[MOD_W-1:0];
        q_nxt   = {q_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[MOD_W-1:0];
        q_nxt   = {q_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

>>> design/mau_mul.sv
module mau_mul
  import mau_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  mod_t op_a,
  input  mod_t op_b,
  input  mod_t modulus,
  output logic done,
  output mod_t prod
);

  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  mod_t a_r, a_nxt;
  mod_t b_r, b_nxt;
  mod_t acc_r, acc_nxt;

  // double-and-add, one multiplier bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = op_a;
      b_nxt    = op_b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (b_r[0]) acc_nxt = add_mod(acc_r, a_r, modulus);
        a_nxt = add_mod(a_r, a_r, modulus);
        b_nxt = {1'b0, b_r[MOD_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
